// ===== hdl/sbrc_pkg.sv =====
// Shared types and constants for the swap buffer ring controller.
// No dependencies; imported by sbrc_arbiter and swap_buffer_ring_controller.
package sbrc_pkg;

    localparam int MAX_BUFFERS_DEF = 4;

    typedef enum logic [2:0] {
        BUF_EMPTY   = 3'd0,
        BUF_READING = 3'd1,
        BUF_READ    = 3'd2,
        BUF_WRITING = 3'd3,
        BUF_WROTE   = 3'd4
    } buf_state_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NONE   = 2'd1,
        STATUS_MISUSE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_BUFFER_COUNT  = 2'd0,
        CFG_REPEAT_READS  = 2'd1,
        CFG_REPEAT_WRITES = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] slot;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] granted_slot;
    } result_t;

    typedef struct packed {
        logic [2:0] buffer_count;
        logic       repeat_reads;
        logic       repeat_writes;
    } cfg_t;

endpackage

// ===== hdl/sbrc_arbiter.sv =====
// Single-pass decision logic: one beat against the ring state gives the result
// and the next ring state. Depends on sbrc_pkg.
module sbrc_arbiter #(
    parameter int MAX_BUFFERS = sbrc_pkg::MAX_BUFFERS_DEF,
    localparam int PW = $clog2(MAX_BUFFERS),
    localparam int CW = $clog2(MAX_BUFFERS + 1)
) (
    input  sbrc_pkg::item_t                      item,
    input  sbrc_pkg::cfg_t                       cfg,
    input  sbrc_pkg::buf_state_t [MAX_BUFFERS-1:0] bstate,
    input  logic [PW-1:0]                        rd_ptr,
    input  logic [PW-1:0]                        wr_ptr,
    output sbrc_pkg::buf_state_t [MAX_BUFFERS-1:0] bstate_next,
    output logic [PW-1:0]                        rd_ptr_next,
    output logic [PW-1:0]                        wr_ptr_next,
    output sbrc_pkg::result_t                    result
);
    import sbrc_pkg::*;

    // pointer mod n by repeated subtract; pointer < MAX_BUFFERS and n >= 2
    function automatic logic [PW-1:0] mod_n(input logic [PW-1:0] p, input logic [CW-1:0] n);
        logic [CW-1:0] r;
        r = CW'(p);
        for (int k = 0; k < MAX_BUFFERS / 2; k++)
        begin
            if (r >= n)
                r = r - n;
        end
        return PW'(r);
    endfunction

    function automatic logic [PW-1:0] inc_n(input logic [PW-1:0] p, input logic [CW-1:0] n);
        logic [CW-1:0] s;
        s = CW'(p) + CW'(1);
        return (s == n) ? '0 : PW'(s);
    endfunction

    logic [CW-1:0] n_act;
    logic [PW-1:0] cur_rd, nx_rd, cur_wr, nx_wr;
    logic          any_reading, any_writing;
    buf_state_t    st_cur_rd, st_nx_rd, st_cur_wr, st_nx_wr, st_slot;
    logic          upd;
    logic [PW-1:0] upd_idx;
    buf_state_t    upd_val;
    logic [PW-1:0] gidx;
    status_t       status;

    always_comb
    begin
        if (cfg.buffer_count < 3'd2)
            n_act = CW'(2);
        else if (32'(cfg.buffer_count) > MAX_BUFFERS)
            n_act = CW'(MAX_BUFFERS);
        else
            n_act = CW'(cfg.buffer_count);
    end

    assign cur_rd = mod_n(rd_ptr, n_act);
    assign nx_rd  = inc_n(cur_rd, n_act);
    assign cur_wr = mod_n(wr_ptr, n_act);
    assign nx_wr  = inc_n(cur_wr, n_act);

    // per-entry flags and selects, all entries in parallel
    always_comb
    begin
        any_reading = 1'b0;
        any_writing = 1'b0;
        st_cur_rd   = BUF_EMPTY;
        st_nx_rd    = BUF_EMPTY;
        st_cur_wr   = BUF_EMPTY;
        st_nx_wr    = BUF_EMPTY;
        st_slot     = BUF_EMPTY;
        for (int i = 0; i < MAX_BUFFERS; i++)
        begin
            if (CW'(i) < n_act)
            begin
                if (bstate[i] == BUF_READING)
                    any_reading = 1'b1;
                if (bstate[i] == BUF_WRITING)
                    any_writing = 1'b1;
            end
            if (cur_rd == PW'(i))
                st_cur_rd = bstate[i];
            if (nx_rd == PW'(i))
                st_nx_rd = bstate[i];
            if (cur_wr == PW'(i))
                st_cur_wr = bstate[i];
            if (nx_wr == PW'(i))
                st_nx_wr = bstate[i];
            if (32'(item.slot) == i)
                st_slot = bstate[i];
        end
    end

    always_comb
    begin
        status      = STATUS_MISUSE;
        gidx        = '0;
        upd         = 1'b0;
        upd_idx     = '0;
        upd_val     = BUF_EMPTY;
        rd_ptr_next = rd_ptr;
        wr_ptr_next = wr_ptr;
        case (item.kind)
            KIND_READ:
            begin
                if (any_reading)
                    status = STATUS_MISUSE;
                else if (cfg.repeat_reads && nx_rd != cur_wr && st_nx_rd == BUF_WROTE)
                    gidx = nx_rd;
                else if (cfg.repeat_reads && st_cur_rd == BUF_READ)
                    gidx = cur_rd;
                else if (!cfg.repeat_reads && st_nx_rd == BUF_WROTE)
                    gidx = nx_rd;
                else
                    status = STATUS_NONE;
                if (!any_reading
                    && ((cfg.repeat_reads && nx_rd != cur_wr && st_nx_rd == BUF_WROTE)
                        || (cfg.repeat_reads && st_cur_rd == BUF_READ)
                        || (!cfg.repeat_reads && st_nx_rd == BUF_WROTE)))
                begin
                    status      = STATUS_OK;
                    upd         = 1'b1;
                    upd_idx     = gidx;
                    upd_val     = BUF_READING;
                    rd_ptr_next = gidx;
                end
            end
            KIND_WRITE:
            begin
                if (any_writing)
                    status = STATUS_MISUSE;
                else if (cfg.repeat_writes
                         && ((nx_wr != cur_rd && st_nx_wr == BUF_READ) || st_nx_wr == BUF_EMPTY))
                    gidx = nx_wr;
                else if (cfg.repeat_writes && st_cur_wr == BUF_WROTE)
                    gidx = cur_wr;
                else if (!cfg.repeat_writes && (st_nx_wr == BUF_READ || st_nx_wr == BUF_EMPTY))
                    gidx = nx_wr;
                else
                    status = STATUS_NONE;
                if (!any_writing
                    && ((cfg.repeat_writes
                         && ((nx_wr != cur_rd && st_nx_wr == BUF_READ)
                             || st_nx_wr == BUF_EMPTY))
                        || (cfg.repeat_writes && st_cur_wr == BUF_WROTE)
                        || (!cfg.repeat_writes
                            && (st_nx_wr == BUF_READ || st_nx_wr == BUF_EMPTY))))
                begin
                    status      = STATUS_OK;
                    upd         = 1'b1;
                    upd_idx     = gidx;
                    upd_val     = BUF_WRITING;
                    wr_ptr_next = gidx;
                end
            end
            KIND_FINISH:
            begin
                // a slot past the physical ring is misuse; past the active count is fine
                if (32'(item.slot) < MAX_BUFFERS && st_slot == BUF_READING)
                begin
                    status  = STATUS_OK;
                    upd     = 1'b1;
                    upd_idx = PW'(item.slot);
                    upd_val = BUF_READ;
                end
                else if (32'(item.slot) < MAX_BUFFERS && st_slot == BUF_WRITING)
                begin
                    status  = STATUS_OK;
                    upd     = 1'b1;
                    upd_idx = PW'(item.slot);
                    upd_val = BUF_WROTE;
                end
                else
                    status = STATUS_MISUSE;
            end
            default:
                status = STATUS_MISUSE;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_BUFFERS; i++)
        begin
            bstate_next[i] = (upd && upd_idx == PW'(i)) ? upd_val : bstate[i];
        end
    end

    assign result.status       = status;
    assign result.granted_slot = (status == STATUS_OK) ? 2'(gidx) : 2'd0;

endmodule

// ===== hdl/swap_buffer_ring_controller.sv =====
// Top level of the swap buffer ring controller: beat capture, ring state,
// configuration registers and result register. Depends on sbrc_pkg, sbrc_arbiter.
//
//  port group                  dir  handshake
//  start/busy/item             in   accepted on start && !busy
//  done/result                 out  one-cycle strobe, no back-pressure
//  cfg_en/cfg_addr/cfg_data    in   written on cfg_en
//
// A beat is captured at the accepting edge, passes the arbiter in the next
// cycle and its result is held with done in the cycle after that. One beat
// per cycle is sustained, set by the single arbiter pass between the input
// and result registers. busy never rises. Reset leaves every buffer empty,
// both pointers at zero, two buffers in use and both repeat modes off.
// Results cannot be stalled.
module swap_buffer_ring_controller #(
    parameter int MAX_BUFFERS = sbrc_pkg::MAX_BUFFERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sbrc_pkg::item_t   item,
    output logic              done,
    output sbrc_pkg::result_t result,
    input  logic              cfg_en,
    input  logic [1:0]        cfg_addr,
    input  logic [2:0]        cfg_data
);
    import sbrc_pkg::*;

    localparam int PW = $clog2(MAX_BUFFERS);

    cfg_t                         cfg_reg;
    buf_state_t [MAX_BUFFERS-1:0] bstate_reg, bstate_next;
    logic [PW-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]                wr_ptr_reg, wr_ptr_next;
    item_t                        item_reg;
    logic                         pend_reg;
    result_t                      result_reg, result_next;
    logic                         done_reg;

    assign busy = 1'b0;

    sbrc_arbiter #(
        .MAX_BUFFERS (MAX_BUFFERS)
    ) u_arbiter (
        .item        (item_reg),
        .cfg         (cfg_reg),
        .bstate      (bstate_reg),
        .rd_ptr      (rd_ptr_reg),
        .wr_ptr      (wr_ptr_reg),
        .bstate_next (bstate_next),
        .rd_ptr_next (rd_ptr_next),
        .wr_ptr_next (wr_ptr_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_count  <= 3'd2;
            cfg_reg.repeat_reads  <= 1'b0;
            cfg_reg.repeat_writes <= 1'b0;
            for (int i = 0; i < MAX_BUFFERS; i++)
            begin
                bstate_reg[i] <= BUF_EMPTY;
            end
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_en)
            begin
                case (cfg_addr)
                    CFG_BUFFER_COUNT:  cfg_reg.buffer_count  <= cfg_data;
                    CFG_REPEAT_READS:  cfg_reg.repeat_reads  <= cfg_data[0];
                    CFG_REPEAT_WRITES: cfg_reg.repeat_writes <= cfg_data[0];
                    default:           ;
                endcase
            end
            pend_reg <= start && !busy;
            done_reg <= pend_reg;
            if (pend_reg)
            begin
                bstate_reg <= bstate_next;
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        if (pend_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
